[hdl/causal_attention_rope_row_defines.svh]
// assertion macros for the causal attention row engine
// used by the top level; expects clk and arst_n in scope
`ifndef CAUSAL_ATTENTION_ROPE_ROW_DEFINES_SVH
`define CAUSAL_ATTENTION_ROPE_ROW_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CARR_AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CARR_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/carr_pkg.sv]
// shared constants, tables, command types and helper functions
// for the causal attention row engine; no dependencies
package carr_pkg;

	localparam int SEQ_LEN    = 32;
	localparam int HEAD_DIM   = 32;
	localparam int DATA_WIDTH = 16;

	localparam int IDX_W      = $clog2(SEQ_LEN);
	localparam int COL_W      = $clog2(HEAD_DIM);
	localparam int STORE_SIZE = SEQ_LEN * HEAD_DIM;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int PAIRS      = HEAD_DIM / 2;
	localparam int PAIR_W     = $clog2(PAIRS);

	localparam logic [31:0] FRAC_TURN_Q32 = 32'd683565276;
	localparam logic [31:0] LOG2_BASE_Q16 = 32'd870824;

	// datapath widths
	localparam int PROD_W  = 2 * DATA_WIDTH;
	localparam int ACC_W   = 2 * DATA_WIDTH + COL_W;
	localparam int INV_W   = 17;
	localparam int SPROD_W = ACC_W + INV_W;
	localparam int SCORE_W = SPROD_W - 28;
	localparam int W_W     = 17;
	localparam int TOT_W   = W_W + IDX_W;
	localparam int NUM_W   = W_W + 1 + DATA_WIDTH + IDX_W;
	localparam int DIV_W   = NUM_W + 1;
	localparam int CNT_W   = $clog2(DIV_W);

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	// input function codes
	localparam logic [1:0] FUNC_LOAD_Q  = 2'd0;
	localparam logic [1:0] FUNC_LOAD_K  = 2'd1;
	localparam logic [1:0] FUNC_LOAD_V  = 2'd2;
	localparam logic [1:0] FUNC_COMPUTE = 2'd3;

	// datapath step commands
	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_RD0, OP_RD1, OP_RMUL, OP_RY, OP_DMUL, OP_DACC,
		OP_SMUL, OP_SRND, OP_WFRAC, OP_WINT, OP_ORD, OP_OMUL, OP_OACC,
		OP_DINIT, OP_DSTEP, OP_OUTLD
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic              is_key;
		logic [IDX_W-1:0]  pos;
		logic [PAIR_W-1:0] pair;
		logic [IDX_W-1:0]  j;
		logic [COL_W-1:0]  a;
		logic              first;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	// 2^(-i/16) in Q16
	function automatic logic [16:0] pow2_neg(input logic [3:0] i);
		logic [16:0] r;
		case (i)
			4'd0: r = 17'd65536;   4'd1: r = 17'd62757;
			4'd2: r = 17'd60097;   4'd3: r = 17'd57549;
			4'd4: r = 17'd55109;   4'd5: r = 17'd52773;
			4'd6: r = 17'd50535;   4'd7: r = 17'd48393;
			4'd8: r = 17'd46341;   4'd9: r = 17'd44376;
			4'd10: r = 17'd42495;  4'd11: r = 17'd40693;
			4'd12: r = 17'd38968;  4'd13: r = 17'd37316;
			4'd14: r = 17'd35734;  4'd15: r = 17'd34219;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	// quarter-wave sine in Q14, 17 points
	function automatic logic [14:0] sin_q14(input logic [4:0] i);
		logic [14:0] r;
		case (i)
			5'd0: r = 15'd0;       5'd1: r = 15'd1606;
			5'd2: r = 15'd3196;    5'd3: r = 15'd4756;
			5'd4: r = 15'd6270;    5'd5: r = 15'd7723;
			5'd6: r = 15'd9102;    5'd7: r = 15'd10394;
			5'd8: r = 15'd11585;   5'd9: r = 15'd12665;
			5'd10: r = 15'd13623;  5'd11: r = 15'd14449;
			5'd12: r = 15'd15137;  5'd13: r = 15'd15679;
			5'd14: r = 15'd16069;  5'd15: r = 15'd16305;
			default: r = 15'd16384;
		endcase
		return r;
	endfunction

	// exp(-n) for integer n in Q16
	function automatic logic [16:0] exp_int(input logic [3:0] i);
		logic [16:0] r;
		case (i)
			4'd0: r = 17'd65536;  4'd1: r = 17'd24109;
			4'd2: r = 17'd8869;   4'd3: r = 17'd3263;
			4'd4: r = 17'd1200;   4'd5: r = 17'd442;
			4'd6: r = 17'd162;    4'd7: r = 17'd60;
			4'd8: r = 17'd22;     4'd9: r = 17'd8;
			4'd10: r = 17'd3;     4'd11: r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// exp(-f) for f in sixteenths in Q16
	function automatic logic [16:0] exp_frac(input logic [4:0] i);
		logic [16:0] r;
		case (i)
			5'd0: r = 17'd65536;   5'd1: r = 17'd61565;
			5'd2: r = 17'd57835;   5'd3: r = 17'd54331;
			5'd4: r = 17'd51039;   5'd5: r = 17'd47947;
			5'd6: r = 17'd45042;   5'd7: r = 17'd42313;
			5'd8: r = 17'd39750;   5'd9: r = 17'd37341;
			5'd10: r = 17'd35079;  5'd11: r = 17'd32954;
			5'd12: r = 17'd30957;  5'd13: r = 17'd29081;
			5'd14: r = 17'd27319;  5'd15: r = 17'd25664;
			default: r = 17'd24109;
		endcase
		return r;
	endfunction

	// per-pair rotation step in turns per position, Q0.32
	typedef logic [31:0] step_tab_t [PAIRS];

	function automatic step_tab_t gen_step_tab();
		step_tab_t   t;
		logic [63:0] e;
		logic [63:0] st;
		for (int k = 0; k < PAIRS; k++) begin
			e = (64'(2 * k) * 64'(LOG2_BASE_Q16)) / 64'(HEAD_DIM);
			st = (64'(FRAC_TURN_Q32) * 64'(pow2_neg(e[15:12]))) >> (16 + e[31:16]);
			t[k] = st[31:0];
		end
		return t;
	endfunction

	localparam step_tab_t STEP_TAB = gen_step_tab();

	// integer square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] n0);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] b;
		n = n0;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	localparam logic signed [INV_W-1:0] INV_SCALE =
		INV_W'(isqrt64((64'd1 << 32) / 64'(HEAD_DIM)));

	// sine of a phase in turns (Q0.32), Q14 result
	function automatic data_t sin_turn(input logic [31:0] ph);
		logic [16:0] p;
		logic [4:0]  idx;
		logic [11:0] fr;
		logic [14:0] s0;
		logic [14:0] s1;
		logic [14:0] mag;
		logic [26:0] d;
		p = {1'b0, ph[29:14]};
		if (ph[30]) begin
			p = 17'h10000 - p;
		end
		idx = p[16:12];
		fr = p[11:0];
		s0 = '0;
		s1 = '0;
		if (idx[4]) begin
			mag = 15'd16384;
		end else begin
			s0 = sin_q14(idx);
			s1 = sin_q14(idx + 5'd1);
			d = 27'(s1 - s0) * 27'(fr);
			mag = s0 + 15'(d >> 12);
		end
		return ph[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	// saturate to the data width
	function automatic data_t sat_dw(input logic signed [47:0] v);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = (48'sd1 <<< (DATA_WIDTH - 1)) - 48'sd1;
		lo = -hi - 48'sd1;
		if (v > hi) return data_t'(hi[DATA_WIDTH-1:0]);
		if (v < lo) return data_t'(lo[DATA_WIDTH-1:0]);
		return data_t'(v[DATA_WIDTH-1:0]);
	endfunction

endpackage

[hdl/carr_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module carr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/carr_ctrl.sv]
// controller state machine of the attention row engine
// depends on carr_pkg
module carr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          func,
	input  logic [4:0]          row,
	output logic                in_stall,
	input  carr_pkg::dp_status_t status,
	output carr_pkg::dp_cmd_t   cmd
);
	import carr_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD0, ST_RD1, ST_RMUL, ST_RY, ST_DMUL, ST_DACC, ST_SMUL,
		ST_SRND, ST_WFRAC, ST_WINT, ST_ORD, ST_OMUL, ST_OACC, ST_DINIT,
		ST_DIV, ST_OUT
	} state_t;

	localparam logic [PAIR_W-1:0] PAIR_LAST = PAIR_W'(PAIRS - 1);
	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(HEAD_DIM - 1);
	localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(DIV_W - 1);

	state_t            state_q;
	logic [IDX_W-1:0]  row_q;
	logic              is_key_q;
	logic [PAIR_W-1:0] k_q;
	logic [IDX_W-1:0]  j_q;
	logic [COL_W-1:0]  a_q;
	logic [CNT_W-1:0]  cnt_q;

	assign in_stall = (state_q != ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			row_q    <= '0;
			is_key_q <= 1'b0;
			k_q      <= '0;
			j_q      <= '0;
			a_q      <= '0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && func == FUNC_COMPUTE && int'(row) < SEQ_LEN) begin
						row_q    <= IDX_W'(row);
						is_key_q <= 1'b0;
						k_q      <= '0;
						j_q      <= '0;
						state_q  <= ST_RD0;
					end
				end
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_RMUL;
				ST_RMUL: state_q <= ST_RY;
				ST_RY: begin
					if (is_key_q) begin
						state_q <= ST_DMUL;
					end else if (k_q == PAIR_LAST) begin
						is_key_q <= 1'b1;
						k_q      <= '0;
						j_q      <= '0;
						state_q  <= ST_RD0;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_RD0;
					end
				end
				ST_DMUL: state_q <= ST_DACC;
				ST_DACC: begin
					if (k_q == PAIR_LAST) begin
						state_q <= ST_SMUL;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_RD0;
					end
				end
				ST_SMUL: state_q <= ST_SRND;
				ST_SRND: begin
					k_q <= '0;
					if (j_q == row_q) begin
						j_q     <= '0;
						state_q <= ST_WFRAC;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_RD0;
					end
				end
				ST_WFRAC: state_q <= ST_WINT;
				ST_WINT: begin
					if (j_q == row_q) begin
						j_q     <= '0;
						a_q     <= '0;
						state_q <= ST_ORD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_WFRAC;
					end
				end
				ST_ORD:  state_q <= ST_OMUL;
				ST_OMUL: state_q <= ST_OACC;
				ST_OACC: begin
					if (j_q == row_q) begin
						state_q <= ST_DINIT;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_ORD;
					end
				end
				ST_DINIT: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (status.out_free) begin
						j_q <= '0;
						if (a_q == COL_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							a_q     <= a_q + 1'b1;
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd.op     = OP_NONE;
		cmd.is_key = is_key_q;
		cmd.pos    = is_key_q ? j_q : row_q;
		cmd.pair   = k_q;
		cmd.j      = j_q;
		cmd.a      = a_q;
		cmd.first  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && func != FUNC_COMPUTE) begin
					cmd.op = OP_LOAD;
				end
			end
			ST_RD0:  cmd.op = OP_RD0;
			ST_RD1:  cmd.op = OP_RD1;
			ST_RMUL: cmd.op = OP_RMUL;
			ST_RY:   cmd.op = OP_RY;
			ST_DMUL: cmd.op = OP_DMUL;
			ST_DACC: begin
				cmd.op    = OP_DACC;
				cmd.first = (k_q == '0);
			end
			ST_SMUL: cmd.op = OP_SMUL;
			ST_SRND: begin
				cmd.op    = OP_SRND;
				cmd.first = (j_q == '0);
			end
			ST_WFRAC: cmd.op = OP_WFRAC;
			ST_WINT: begin
				cmd.op    = OP_WINT;
				cmd.first = (j_q == '0);
			end
			ST_ORD:  cmd.op = OP_ORD;
			ST_OMUL: cmd.op = OP_OMUL;
			ST_OACC: begin
				cmd.op    = OP_OACC;
				cmd.first = (j_q == '0);
			end
			ST_DINIT: cmd.op = OP_DINIT;
			ST_DIV:   cmd.op = OP_DSTEP;
			ST_OUT: begin
				if (status.out_free) begin
					cmd.op = OP_OUTLD;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

[hdl/carr_dp.sv]
// datapath of the attention row engine: stores, rotation, scoring,
// softmax weights, weighted sum, divider and output register; uses carr_pkg, carr_ram
module carr_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  carr_pkg::dp_cmd_t    cmd,
	output carr_pkg::dp_status_t status,
	input  logic [1:0]           func,
	input  logic [4:0]           row,
	input  logic [4:0]           col,
	input  logic signed [15:0]   value,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   out_value,
	output logic [4:0]           out_col,
	output logic                 last
);
	import carr_pkg::*;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(HEAD_DIM - 1);
	localparam logic [SCORE_W:0] EXP_LIMIT = (SCORE_W + 1)'(12 << 12);
	localparam logic [DIV_W-1:0] POS_MAX = DIV_W'((1 << (DATA_WIDTH - 1)) - 1);
	localparam logic [DIV_W-1:0] NEG_MAX = DIV_W'(1 << (DATA_WIDTH - 1));

	// configuration
	logic rope_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rope_q <= 1'b1;
		end else if (cfg_we) begin
			rope_q <= cfg_data;
		end
	end

	// stores
	logic              ld_ok;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] pair_addr;
	logic [ADDR_W-1:0] v_addr;
	data_t             wdata;
	logic [DATA_WIDTH-1:0] q_rdata;
	logic [DATA_WIDTH-1:0] k_rdata;
	logic [DATA_WIDTH-1:0] v_rdata;
	data_t             x_rd;

	assign ld_ok     = (cmd.op == OP_LOAD) && (int'(row) < SEQ_LEN) && (int'(col) < HEAD_DIM);
	assign waddr     = ADDR_W'(int'(row) * HEAD_DIM + int'(col));
	assign wdata     = sat_dw(48'(value));
	assign pair_addr = ADDR_W'(int'(cmd.pos) * HEAD_DIM + 2 * int'(cmd.pair)
		+ ((cmd.op == OP_RD1) ? 1 : 0));
	assign v_addr    = ADDR_W'(int'(cmd.j) * HEAD_DIM + int'(cmd.a));
	assign x_rd      = $signed(cmd.is_key ? k_rdata : q_rdata);

	carr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_SIZE)) u_qram (
		.clk   (clk),
		.we    (ld_ok && func == FUNC_LOAD_Q),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (pair_addr),
		.rdata (q_rdata)
	);

	carr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_SIZE)) u_kram (
		.clk   (clk),
		.we    (ld_ok && func == FUNC_LOAD_K),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (pair_addr),
		.rdata (k_rdata)
	);

	carr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_SIZE)) u_vram (
		.clk   (clk),
		.we    (ld_ok && func == FUNC_LOAD_V),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (v_addr),
		.rdata (v_rdata)
	);

	// working registers
	logic [31:0]                ph_q;
	data_t                      c_q;
	data_t                      s_q;
	data_t                      x0_q;
	data_t                      x1_q;
	logic signed [PROD_W-1:0]   m0_q, m1_q, m2_q, m3_q;
	data_t                      y0_q;
	data_t                      y1_q;
	data_t                      qlo_q [PAIRS];
	data_t                      qhi_q [PAIRS];
	logic signed [PROD_W-1:0]   p0_q, p1_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SPROD_W-1:0]  sprod_q;
	logic signed [SCORE_W-1:0]  score_q [SEQ_LEN];
	logic signed [SCORE_W-1:0]  mx_q;
	logic                       wzero_q;
	logic [3:0]                 ei_q;
	logic [16:0]                e_q;
	logic [W_W-1:0]             weight_q [SEQ_LEN];
	logic [TOT_W-1:0]           total_q;
	logic [W_W-1:0]             wsel_q;
	logic signed [W_W+DATA_WIDTH:0] oprod_q;
	logic signed [NUM_W-1:0]    num_q;
	logic                       neg_q;
	logic [TOT_W-1:0]           rem_q;
	logic [DIV_W-1:0]           quo_q;

	// rotation outputs
	logic signed [47:0] t0, t1;
	data_t              y0, y1;

	assign t0 = (48'(m0_q) - 48'(m1_q) + 48'sd8192) >>> 14;
	assign t1 = (48'(m2_q) + 48'(m3_q) + 48'sd8192) >>> 14;
	assign y0 = rope_q ? sat_dw(t0) : x0_q;
	assign y1 = rope_q ? sat_dw(t1) : x1_q;

	// score rounding
	logic signed [SPROD_W-1:0] rnd;
	logic signed [SCORE_W-1:0] sc;

	assign rnd = sprod_q + $signed(SPROD_W'(1 << 27));
	assign sc  = SCORE_W'(rnd >>> 28);

	// exponent, fractional part
	logic signed [SCORE_W:0] sd;
	logic [SCORE_W:0]        xd;
	logic [16:0]             f0, f1;
	logic [24:0]             fm;

	assign sd = {mx_q[SCORE_W-1], mx_q} - {score_q[cmd.j][SCORE_W-1], score_q[cmd.j]};
	assign xd = $unsigned(sd);
	assign f0 = exp_frac({1'b0, xd[11:8]});
	assign f1 = exp_frac({1'b0, xd[11:8]} + 5'd1);
	assign fm = 25'(f0 - f1) * 25'(xd[7:0]);

	// exponent, integer part
	logic [33:0]    pw;
	logic [W_W-1:0] w;

	assign pw = 34'(exp_int(ei_q)) * 34'(e_q);
	assign w  = wzero_q ? '0 : W_W'((pw + 34'd32768) >> 16);

	// divider setup and step
	logic [NUM_W-1:0] mag;
	logic [TOT_W:0]   sh;

	assign mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign sh  = {rem_q, quo_q[DIV_W-1]};

	// final rounding and saturation
	data_t oval;

	always_comb begin
		if (neg_q) begin
			oval = (quo_q > NEG_MAX) ? sat_dw(-48'sd1 <<< 47) : $signed(DATA_WIDTH'(-quo_q));
		end else begin
			oval = (quo_q > POS_MAX) ? sat_dw(48'sd1 <<< 46) : $signed(quo_q[DATA_WIDTH-1:0]);
		end
	end

	// datapath steps
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_RD0: begin
				ph_q <= 32'(32'(cmd.pos) * STEP_TAB[cmd.pair]);
			end
			OP_RD1: begin
				x0_q <= x_rd;
				s_q  <= sin_turn(ph_q);
				c_q  <= sin_turn(ph_q + 32'h4000_0000);
			end
			OP_RMUL: begin
				x1_q <= x_rd;
				m0_q <= x0_q * c_q;
				m1_q <= x_rd * s_q;
				m2_q <= x0_q * s_q;
				m3_q <= x_rd * c_q;
			end
			OP_RY: begin
				y0_q <= y0;
				y1_q <= y1;
				if (!cmd.is_key) begin
					qlo_q[cmd.pair] <= y0;
					qhi_q[cmd.pair] <= y1;
				end
			end
			OP_DMUL: begin
				p0_q <= qlo_q[cmd.pair] * y0_q;
				p1_q <= qhi_q[cmd.pair] * y1_q;
			end
			OP_DACC: begin
				acc_q <= (cmd.first ? '0 : acc_q) + ACC_W'(p0_q) + ACC_W'(p1_q);
			end
			OP_SMUL: begin
				sprod_q <= acc_q * INV_SCALE;
			end
			OP_SRND: begin
				score_q[cmd.j] <= sc;
				if (cmd.first || sc > mx_q) begin
					mx_q <= sc;
				end
			end
			OP_WFRAC: begin
				wzero_q <= (xd >= EXP_LIMIT);
				ei_q    <= xd[15:12];
				e_q     <= f0 - 17'(fm >> 8);
			end
			OP_WINT: begin
				weight_q[cmd.j] <= w;
				total_q <= (cmd.first ? '0 : total_q) + TOT_W'(w);
			end
			OP_ORD: begin
				wsel_q <= weight_q[cmd.j];
			end
			OP_OMUL: begin
				oprod_q <= $signed({1'b0, wsel_q}) * $signed(v_rdata);
			end
			OP_OACC: begin
				num_q <= (cmd.first ? '0 : num_q) + NUM_W'(oprod_q);
			end
			OP_DINIT: begin
				neg_q <= num_q[NUM_W-1];
				rem_q <= '0;
				quo_q <= DIV_W'(mag) + DIV_W'(total_q >> 1);
			end
			OP_DSTEP: begin
				if (sh >= {1'b0, total_q}) begin
					rem_q <= TOT_W'(sh - {1'b0, total_q});
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= TOT_W'(sh);
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUTLD) begin
			out_value <= oval;
			out_col   <= 5'(cmd.a);
			last      <= (cmd.a == COL_LAST);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.op == OP_OUTLD) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	assign status.out_free = !out_valid || !out_stall;

endmodule

[hdl/causal_attention_rope_row.sv]
// top level of the causal attention row engine with rotary positions
// depends on carr_pkg, carr_ctrl, carr_dp, carr_ram and the defines header
//
//   channel   signals                              handshake
//   in        func, row, col, value                in_valid / in_stall
//   out       out_value, out_col, last             out_valid / out_stall
//   config    cfg_data (rope_enable)               cfg_we
//
// a load is taken while idle; the length of a compute of row i is set by the
// per-pair rotation sequence, one ram read port per store and the
// 40-step serial divider run once per output column
// reset leaves rope_enable at 1 and the output empty; stores are not cleared
// out_stall holds the output register; the engine waits only when its next
// result has nowhere to go, and in_stall is high for the whole compute
`include "causal_attention_rope_row_defines.svh"

module causal_attention_rope_row (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [4:0]         row,
	input  logic [4:0]         col,
	input  logic signed [15:0] value,
	input  logic               cfg_we,
	input  logic               cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_value,
	output logic [4:0]         out_col,
	output logic               last
);
	import carr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer
	carr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.row      (row),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and storage
	carr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.func      (func),
		.row       (row),
		.col       (col),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_value (out_value),
		.out_col   (out_col),
		.last      (last)
	);

	// checks
	`CARR_AST_SAME(a_outld_free, cmd.op == OP_OUTLD, status.out_free, "output load while busy")
	`CARR_AST_NEXT(a_compute_busy, in_valid && !in_stall && func == FUNC_COMPUTE && int'(row) < SEQ_LEN, in_stall, "compute accepted but engine idle")
	`CARR_AST_NEXT(a_div_start, cmd.op == OP_DINIT, cmd.op == OP_DSTEP, "divider did not start")

endmodule

[tb/testbench.sv]
// self-checking testbench for the causal attention row engine with rotary positions
// depends on carr_pkg and causal_attention_rope_row; predicts every output row itself
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import carr_pkg::*;

	localparam int ROW_SIZE     = 32;
	localparam int STORE_DEPTH  = 1024;
	localparam int QUIET_LIMIT  = 40000;
	localparam int SETTLE_CYC   = 40;
	// rows whose query, key and value entries are all written before any compute
	localparam int FILL_ROWS    = 2;
	// floor(sqrt(2^32 / 32)) in Q16
	localparam longint SCORE_SCALE = 11585;
	localparam longint unsigned TURN_FRAC = 64'd683565276;
	localparam longint unsigned LOG2_BASE = 64'd870824;

	localparam longint ROT_POW [16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
		48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};
	localparam longint SINE_PTS [17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394,
		11585, 12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};
	localparam longint EXP_WHOLE [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
		22, 8, 3, 1};
	localparam longint EXP_PART [17] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
		42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664, 24109};

	typedef struct {
		logic signed [15:0] val;
		logic [4:0]         col;
		logic               lst;
	} out_elem_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = FUNC_LOAD_Q;
	logic [4:0]         row = '0;
	logic [4:0]         col = '0;
	logic signed [15:0] value = '0;
	logic               cfg_we = 1'b0;
	logic               cfg_data = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] out_value;
	logic [4:0]         out_col;
	logic               last;

	// predictor state
	longint    query_mem [STORE_DEPTH];
	longint    key_mem [STORE_DEPTH];
	longint    val_mem [STORE_DEPTH];
	bit        rope_on = 1'b1;
	out_elem_t expected_elems [$];

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int errors = 0;
	int loads_sent = 0;
	int rows_sent = 0;
	int elems_seen = 0;
	int quiet_cycles = 0;

	causal_attention_rope_row i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .row(row), .col(col), .value(value),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_value(out_value), .out_col(out_col), .last(last)
	);

	always #5 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic longint sat16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// sine of a phase in turns, Q14
	function automatic longint sine_of(input bit [31:0] ph);
		longint p;
		longint idx;
		longint fr;
		longint s;
		p = (ph >> 14) & 32'hFFFF;
		if (ph[30]) p = 65536 - p;
		idx = p >> 12;
		fr = p & 12'hFFF;
		if (idx >= 16) s = 16384;
		else s = SINE_PTS[idx] + (((SINE_PTS[idx + 1] - SINE_PTS[idx]) * fr) >> 12);
		return ph[31] ? -s : s;
	endfunction

	// fetch one row, rotated by position when rope is on
	function automatic void fetch_row(input bit from_key, input int pos,
			output longint dst [ROW_SIZE]);
		longint unsigned e;
		longint unsigned stp;
		bit [31:0] ph;
		longint c;
		longint s;
		longint x0;
		longint x1;
		for (int a = 0; a < ROW_SIZE; a++)
			dst[a] = from_key ? key_mem[pos * ROW_SIZE + a] : query_mem[pos * ROW_SIZE + a];
		if (!rope_on) return;
		for (int k = 0; 2 * k + 1 < ROW_SIZE; k++) begin
			e = (64'(2 * k) * LOG2_BASE) / ROW_SIZE;
			stp = (TURN_FRAC * longint'(ROT_POW[(e >> 12) & 15])) >> (16 + (e >> 16));
			ph = 32'(64'(pos) * stp);
			c = sine_of(ph + 32'h4000_0000);
			s = sine_of(ph);
			x0 = dst[2 * k];
			x1 = dst[2 * k + 1];
			dst[2 * k] = sat16((x0 * c - x1 * s + 8192) >>> 14);
			dst[2 * k + 1] = sat16((x0 * s + x1 * c + 8192) >>> 14);
		end
	endfunction

	// softmax weight for a distance below the maximum score, Q16
	function automatic longint weight_of(input longint x);
		longint fr;
		longint i;
		longint e;
		if (x >= 12 * 4096) return 0;
		fr = x & 12'hFFF;
		i = fr >> 8;
		e = EXP_PART[i] - (((EXP_PART[i] - EXP_PART[i + 1]) * (fr & 8'hFF)) >> 8);
		return (EXP_WHOLE[x >> 12] * e + 32768) >> 16;
	endfunction

	// queue the expected output row for a compute of row r
	function automatic void predict_row(input int r);
		longint qv [ROW_SIZE];
		longint kv [ROW_SIZE];
		longint score [ROW_SIZE];
		longint wt [ROW_SIZE];
		longint acc;
		longint mx;
		longint total;
		longint num;
		longint mag;
		longint qt;
		out_elem_t el;
		fetch_row(1'b0, r, qv);
		for (int j = 0; j <= r; j++) begin
			fetch_row(1'b1, j, kv);
			acc = 0;
			for (int a = 0; a < ROW_SIZE; a++) begin
				acc += qv[a] * kv[a];
				if (acc > (64'sd1 <<< 61)) acc = 64'sd1 <<< 61;
				if (acc < -(64'sd1 <<< 61)) acc = -(64'sd1 <<< 61);
			end
			if (acc > (64'sd1 <<< 46)) acc = 64'sd1 <<< 46;
			if (acc < -(64'sd1 <<< 46)) acc = -(64'sd1 <<< 46);
			score[j] = (acc * SCORE_SCALE + (64'sd1 <<< 27)) >>> 28;
		end
		mx = score[0];
		for (int j = 1; j <= r; j++) if (score[j] > mx) mx = score[j];
		total = 0;
		for (int j = 0; j <= r; j++) begin
			wt[j] = weight_of(mx - score[j]);
			total += wt[j];
		end
		for (int a = 0; a < ROW_SIZE; a++) begin
			num = 0;
			for (int j = 0; j <= r; j++) num += wt[j] * val_mem[j * ROW_SIZE + a];
			mag = (num < 0) ? -num : num;
			qt = (total != 0) ? (mag + total / 2) / total : 0;
			el.val = 16'(sat16((num < 0) ? -qt : qt));
			el.col = 5'(a);
			el.lst = (a == ROW_SIZE - 1);
			expected_elems.push_back(el);
		end
	endfunction

	// ---------------- shared drivers ----------------

	task automatic send_item(input logic [1:0] f, input logic [4:0] r, input logic [4:0] c,
			input logic signed [15:0] v);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		row <= r;
		col <= c;
		value <= v;
		do @(posedge clk); while (in_stall);
		// item accepted at this edge
		case (f)
			FUNC_LOAD_Q: query_mem[r * ROW_SIZE + c] = v;
			FUNC_LOAD_K: key_mem[r * ROW_SIZE + c] = v;
			FUNC_LOAD_V: val_mem[r * ROW_SIZE + c] = v;
			default: predict_row(r);
		endcase
		if (f == FUNC_COMPUTE) rows_sent++;
		else loads_sent++;
	endtask

	// stop offering items and wait for every expected element
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_elems.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_rope(input bit en);
		cfg_we <= 1'b1;
		cfg_data <= en;
		@(posedge clk);
		rope_on = en;
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_elem();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2, 3, 4: return 16'($urandom);
			default: return 16'($signed(17'($urandom_range(0, 8192)) - 17'sd4096));
		endcase
	endfunction

	// ---------------- tests ----------------

	// every entry of the leading rows written once, so computes on them read defined data
	task automatic test_fill();
		for (int r = 0; r < FILL_ROWS; r++)
			for (int c = 0; c < HEAD_DIM; c++) begin
				send_item(FUNC_LOAD_Q, 5'(r), 5'(c), rand_elem());
				send_item(FUNC_LOAD_K, 5'(r), 5'(c), rand_elem());
				send_item(FUNC_LOAD_V, 5'(r), 5'(c), rand_elem());
			end
	endtask

	// first and last filled rows, rope on and off, saturating inputs
	task automatic test_directed();
		send_item(FUNC_COMPUTE, 5'd0, 5'd0, 16'sd0);
		send_item(FUNC_COMPUTE, 5'd1, 5'd31, -16'sd1);
		for (int c = 0; c < HEAD_DIM; c++) begin
			send_item(FUNC_LOAD_Q, 5'd1, 5'(c), (c % 2) ? -16'sh8000 : 16'sh7FFF);
			send_item(FUNC_LOAD_K, 5'd1, 5'(c), 16'sh7FFF);
		end
		send_item(FUNC_COMPUTE, 5'd1, 5'd0, 16'sd0);
		drain();
		write_rope(1'b0);
		send_item(FUNC_COMPUTE, 5'd1, 5'd0, 16'sd0);
		send_item(FUNC_COMPUTE, 5'd0, 5'd0, 16'sd0);
		drain();
		write_rope(1'b1);
	endtask

	// loads anywhere, computes only on filled rows
	task automatic random_burst(input int n);
		logic [4:0] r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 25) begin
				r = 5'($urandom_range(0, FILL_ROWS - 1));
				send_item(FUNC_COMPUTE, r, 5'($urandom), 16'($urandom));
			end else begin
				send_item(2'($urandom_range(0, 2)), 5'($urandom), 5'($urandom), rand_elem());
			end
		end
	endtask

	// random mix across idle and stall settings, toggling rope between phases
	task automatic test_random();
		idle_pct = 0;  stall_pct = 0;  random_burst(10);  drain();
		write_rope(1'b0);
		idle_pct = 48; stall_pct = 0;  random_burst(10);  drain();
		write_rope(1'b1);
		idle_pct = 0;  stall_pct = 48; random_burst(10);  drain();
		write_rope(1'b0);
		idle_pct = 6;  stall_pct = 6;  random_burst(10);  drain();
		write_rope(1'b1);
	endtask

	// long output hold while items keep coming, then a full pause
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 3000;
		send_item(FUNC_COMPUTE, 5'd1, 5'd0, 16'sd0);
		send_item(FUNC_COMPUTE, 5'd0, 5'd0, 16'sd0);
		for (int i = 0; i < 8; i++)
			send_item(FUNC_LOAD_V, 5'($urandom_range(0, FILL_ROWS - 1)), 5'($urandom),
				rand_elem());
		send_item(FUNC_COMPUTE, 5'd1, 5'd0, 16'sd0);
		drain();
		send_item(FUNC_COMPUTE, 5'd0, 5'd0, 16'sd0);
		drain();
	endtask

	// ---------------- output side ----------------

	// receiver stall, with a counted long hold when requested
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	// compare each accepted element with the oldest expectation
	always @(posedge clk) begin
		out_elem_t exp_el;
		if (arst_n && out_valid && !out_stall) begin
			elems_seen++;
			if (expected_elems.size() == 0) begin
				$display("%0t: unexpected element val=%0d col=%0d last=%0b",
					$time, out_value, out_col, last);
				errors++;
			end else begin
				exp_el = expected_elems.pop_front();
				if (out_value !== exp_el.val) begin
					$display("%0t: out_value expected %0d actual %0d (col %0d)",
						$time, exp_el.val, out_value, exp_el.col);
					errors++;
				end
				if (out_col !== exp_el.col) begin
					$display("%0t: out_col expected %0d actual %0d",
						$time, exp_el.col, out_col);
					errors++;
				end
				if (last !== exp_el.lst) begin
					$display("%0t: last expected %0b actual %0b (col %0d)",
						$time, exp_el.lst, last, exp_el.col);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted item on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, %0d elements still expected", $time,
				expected_elems.size());
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill();
		test_directed();
		test_random();
		test_backpressure();
		drain();
		if (expected_elems.size() != 0) begin
			$display("%0t: %0d expected elements never arrived", $time,
				expected_elems.size());
			errors++;
		end
		$display("covered %0d loads and %0d row computes, %0d output elements checked",
			loads_sent, rows_sent, elems_seen);
		$display("rope on and off, idle and stall mixes, long output hold; %0d mismatches",
			errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
